FILE: design/x10cs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package x10cs_pkg;

  localparam int MAX_PACKET = 9;
  localparam int IDLE_TICKS = 13;
  localparam int TIME_TICKS = 60;

  localparam logic [7:0] POLL_BYTE     = 8'h5A;
  localparam logic [7:0] ACK_BYTE      = 8'hC3;
  localparam logic [7:0] TIME_REQ_BYTE = 8'hA5;
  localparam logic [7:0] TIME_CMD_BYTE = 8'h9B;
  localparam logic [7:0] MENU_BYTE     = 8'h21;
  localparam logic [3:0] FN_ON  = 4'h2;
  localparam logic [3:0] FN_OFF = 4'h3;
  localparam logic [3:0] UNIT1 = 4'h6;
  localparam logic [3:0] UNIT2 = 4'hE;
  localparam logic [3:0] UNIT3 = 4'h2;
  localparam logic [3:0] UNIT4 = 4'hA;
  localparam logic [3:0] UNIT5 = 4'h1;
  localparam logic [3:0] UNIT6 = 4'h9;

  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_IDLE = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam logic [1:0] IDLE_SCAN = 2'd0;
  localparam logic [1:0] IDLE_CAM1 = 2'd1;

  localparam logic [1:0] REG_MAX_CAMERA  = 2'd0;
  localparam logic [1:0] REG_SCAN_PERIOD = 2'd1;
  localparam logic [1:0] REG_HOUSE_CODE  = 2'd2;
  localparam logic [1:0] REG_IDLE_MODE   = 2'd3;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [3:0] video_enable;
    logic       scanning;
    logic       last;
  } out_item_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;      // take the item and apply its immediate effect
    logic pkt_step;  // process one packet byte
    logic pkt_init;  // start packet processing
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic       ack;       // item needs an ack byte
    logic       tmsg;      // item needs a time message
    logic       pkt_run;   // packet bytes still to process
    logic [7:0] house_byte;
  } dp_stat_t;

  function automatic logic [3:0] house_map(input logic [3:0] h);
    logic [3:0] r;
    case (h)
      4'd0: r = 4'h6;   4'd1: r = 4'hE;   4'd2: r = 4'h2;   4'd3: r = 4'hA;
      4'd4: r = 4'h1;   4'd5: r = 4'h9;   4'd6: r = 4'h5;   4'd7: r = 4'hD;
      4'd8: r = 4'h7;   4'd9: r = 4'hF;   4'd10: r = 4'h3;  4'd11: r = 4'hB;
      4'd12: r = 4'h0;  4'd13: r = 4'h8;  4'd14: r = 4'h4;  default: r = 4'hC;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: design/x10_camera_switch_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// Camera switch controller: takes serial bytes, five-second ticks and start-up
// idle requests as items and gives one result per byte to transmit (ack, time
// message) or a single result if none, with the video enable and scan state
// after the item. One item at a time: the item is loaded as it is accepted in
// the idle state and its flags are read in the loaded state; a completed packet
// is then worked through in a set-up state and a step state for each code byte,
// then the results are given one at a time, held while the output stalls.
module x10_camera_switch_controller (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire x10cs_pkg::in_item_t   in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output x10cs_pkg::out_item_t       out_data,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [3:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import x10cs_pkg::*;

  logic [2:0] max_camera, scan_period;
  logic [3:0] house_code;
  logic [1:0] idle_mode;
  dp_cmd_t cmd;
  dp_stat_t stat;
  logic [3:0] video_enable;
  logic scanning;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_camera <= 3'd4; scan_period <= 3'd0; house_code <= 4'd15; idle_mode <= 2'd0;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      case (paddr[3:2])
        REG_MAX_CAMERA:  max_camera <= pwdata[2:0];
        REG_SCAN_PERIOD: scan_period <= pwdata[2:0];
        REG_HOUSE_CODE:  house_code <= pwdata[3:0];
        REG_IDLE_MODE:   idle_mode <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MAX_CAMERA:  prdata = {29'd0, max_camera};
      REG_SCAN_PERIOD: prdata = {29'd0, scan_period};
      REG_HOUSE_CODE:  prdata = {28'd0, house_code};
      REG_IDLE_MODE:   prdata = {30'd0, idle_mode};
      default:         prdata = 32'd0;
    endcase
  end

  x10cs_datapath u_dp (
    .clk, .rst, .item(in_data), .cmd, .max_camera, .scan_period, .house_code,
    .idle_mode, .stat, .video_enable, .scanning
  );

  x10cs_control u_ctl (
    .clk, .rst, .in_valid, .in_stall, .out_item(out_data), .out_valid, .out_stall,
    .cmd, .stat, .video_enable, .scanning
  );

endmodule
`default_nettype wire

FILE: design/x10cs_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module x10cs_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire x10cs_pkg::in_item_t item,
  input  wire x10cs_pkg::dp_cmd_t  cmd,
  input  wire logic [2:0]          max_camera,
  input  wire logic [2:0]          scan_period,
  input  wire logic [3:0]          house_code,
  input  wire logic [1:0]          idle_mode,
  output x10cs_pkg::dp_stat_t      stat,
  output logic [3:0]               video_enable,
  output logic                     scanning
);
  import x10cs_pkg::*;

  logic [2:0] camera, camera_next;
  logic [3:0] idle_count, idle_count_next;
  logic [2:0] scan_ticks, scan_ticks_next;
  logic [5:0] time_ticks, time_ticks_next;
  logic time_pending, time_pending_next;
  logic first_byte_pending, first_byte_pending_next;
  logic receiving, receiving_next;
  logic [3:0] expected_count, expected_count_next;
  logic [3:0] fill_index, fill_index_next;
  logic address_valid, address_valid_next;
  logic [3:0] latched_house, latched_house_next;
  logic [3:0] latched_unit, latched_unit_next;
  logic ack, ack_next, tmsg, tmsg_next;
  logic [7:0] packet_store [MAX_PACKET];
  logic [7:0] mask, mask_next;
  logic [3:0] px, px_next;
  logic pkt_run, pkt_run_next;
  logic store_we;
  logic [3:0] hmap;
  logic [7:0] b;
  logic [2:0] uc, top, nxt;

  assign hmap = house_map(house_code);
  assign stat.ack = ack;
  assign stat.tmsg = tmsg;
  assign stat.pkt_run = pkt_run;
  assign stat.house_byte = {hmap, 4'h0};
  assign scanning = (idle_count == 4'd0);
  assign b = packet_store[px];
  assign top = (max_camera > 3'd4) ? 3'd4 : max_camera;
  assign nxt = (camera + 3'd1 > top) ? 3'd1 : camera + 3'd1;

  always_comb begin
    case (camera)
      3'd1: video_enable = 4'b0001;
      3'd2: video_enable = 4'b0010;
      3'd3: video_enable = 4'b0100;
      3'd4: video_enable = 4'b1000;
      default: video_enable = 4'b0000;
    endcase
    case (latched_unit)
      UNIT1: uc = 3'd1;
      UNIT2: uc = 3'd2;
      UNIT3: uc = 3'd3;
      UNIT4: uc = 3'd4;
      default: uc = 3'd0;
    endcase
  end

  always_comb begin
    camera_next = camera; idle_count_next = idle_count;
    scan_ticks_next = scan_ticks; time_ticks_next = time_ticks;
    time_pending_next = time_pending; first_byte_pending_next = first_byte_pending;
    receiving_next = receiving; expected_count_next = expected_count;
    fill_index_next = fill_index; address_valid_next = address_valid;
    latched_house_next = latched_house; latched_unit_next = latched_unit;
    ack_next = ack; tmsg_next = tmsg; mask_next = mask; px_next = px;
    pkt_run_next = pkt_run; store_we = 1'b0;
    if (cmd.load) begin
      ack_next = 1'b0; tmsg_next = 1'b0; pkt_run_next = 1'b0;
      case (item.opcode)
        OP_BYTE: begin
          if (first_byte_pending && item.rx_byte != MENU_BYTE) begin
            first_byte_pending_next = 1'b0;
          end
          if (!receiving) begin
            if (item.rx_byte == POLL_BYTE) begin
              ack_next = 1'b1; receiving_next = 1'b1;
              expected_count_next = 4'd0; fill_index_next = 4'd0;
            end
            if (item.rx_byte == TIME_REQ_BYTE || time_pending ||
                (first_byte_pending && item.rx_byte != MENU_BYTE)) begin
              tmsg_next = 1'b1;
              time_pending_next = 1'b0;
            end
          end else begin
            if (first_byte_pending && item.rx_byte != MENU_BYTE) time_pending_next = 1'b1;
            if (expected_count == 4'd0) begin
              if (item.rx_byte > 8'(MAX_PACKET)) receiving_next = 1'b0;
              else expected_count_next = item.rx_byte[3:0];
            end else begin
              store_we = (fill_index < 4'(MAX_PACKET));
              fill_index_next = fill_index + 4'd1;
              if (fill_index + 4'd1 >= expected_count) begin
                receiving_next = 1'b0;
                // packet_store[0] may be this byte
                pkt_run_next = 1'b1;
              end
            end
          end
        end
        OP_TICK: begin
          if (idle_count == 4'd0) begin
            if (scan_ticks >= scan_period) begin
              first_byte_pending_next = 1'b0;
              camera_next = nxt; scan_ticks_next = 3'd0;
            end else begin
              scan_ticks_next = scan_ticks + 3'd1;
            end
          end else if ({1'b0, idle_count} + 5'd1 > 5'(IDLE_TICKS)) begin
            idle_count_next = 4'd1;
            if (idle_mode == IDLE_SCAN) idle_count_next = 4'd0;
            else if (idle_mode == IDLE_CAM1) camera_next = 3'd1;
          end else begin
            idle_count_next = idle_count + 4'd1;
          end
          if ({1'b0, time_ticks} + 7'd1 > 7'(TIME_TICKS)) begin
            time_pending_next = 1'b1; time_ticks_next = 6'd0;
          end else begin
            time_ticks_next = time_ticks + 6'd1;
          end
        end
        OP_IDLE: begin
          idle_count_next = 4'd1;
          if (idle_mode == IDLE_SCAN) idle_count_next = 4'd0;
          else if (idle_mode == IDLE_CAM1) camera_next = 3'd1;
        end
        default: ;
      endcase
    end else if (cmd.pkt_init) begin
      mask_next = packet_store[0];
      px_next = 4'd1;
      pkt_run_next = (expected_count > 4'd1);
    end else if (cmd.pkt_step) begin
      if (mask[0]) begin
        if (address_valid && latched_house == hmap) begin
          if (b[3:0] == FN_ON) begin
            if (uc != 3'd0) begin
              camera_next = uc; idle_count_next = 4'd1;
            end else if (latched_unit == UNIT5) begin
              idle_count_next = 4'd0;
            end else if (latched_unit == UNIT6) begin
              camera_next = (camera <= 3'd1) ? 3'd4 : camera - 3'd1;
              idle_count_next = 4'd1;
            end
          end else if (b[3:0] == FN_OFF) begin
            if (uc != 3'd0 && uc == camera) begin
              if (idle_mode == IDLE_SCAN) idle_count_next = 4'd0;
              else if (idle_mode == IDLE_CAM1) begin
                camera_next = 3'd1; idle_count_next = 4'd1;
              end
            end else if (latched_unit == UNIT5) begin
              camera_next = 3'd0; idle_count_next = 4'd1;
            end else if (latched_unit == UNIT6) begin
              camera_next = (camera >= 3'd4) ? 3'd1 : camera + 3'd1;
              idle_count_next = 4'd1;
            end
          end
        end
      end else begin
        latched_house_next = b[7:4]; latched_unit_next = b[3:0];
        address_valid_next = 1'b1;
      end
      mask_next = {1'b0, mask[7:1]};
      px_next = px + 4'd1;
      pkt_run_next = (px + 4'd1 < expected_count) && (px + 4'd1 < 4'(MAX_PACKET));
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) packet_store[fill_index] <= item.rx_byte;
    mask <= mask_next;
    px <= px_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      camera <= 3'd1; idle_count <= 4'd1; scan_ticks <= 3'd0; time_ticks <= 6'd0;
      time_pending <= 1'b0; first_byte_pending <= 1'b1; receiving <= 1'b0;
      expected_count <= 4'd0; fill_index <= 4'd0; address_valid <= 1'b0;
      latched_house <= 4'd0; latched_unit <= 4'd0;
      ack <= 1'b0; tmsg <= 1'b0; pkt_run <= 1'b0;
    end else begin
      camera <= camera_next; idle_count <= idle_count_next;
      scan_ticks <= scan_ticks_next; time_ticks <= time_ticks_next;
      time_pending <= time_pending_next; first_byte_pending <= first_byte_pending_next;
      receiving <= receiving_next; expected_count <= expected_count_next;
      fill_index <= fill_index_next; address_valid <= address_valid_next;
      latched_house <= latched_house_next; latched_unit <= latched_unit_next;
      ack <= ack_next; tmsg <= tmsg_next; pkt_run <= pkt_run_next;
    end
  end

endmodule
`default_nettype wire

FILE: design/x10cs_control.sv
`timescale 1ns / 1ps
`default_nettype none
module x10cs_control (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  output x10cs_pkg::out_item_t      out_item,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output x10cs_pkg::dp_cmd_t        cmd,
  input  wire x10cs_pkg::dp_stat_t  stat,
  input  wire logic [3:0]           video_enable,
  input  wire logic                 scanning
);
  import x10cs_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_LOADED, S_PINIT, S_PSTEP, S_EMIT} state_t;

  state_t state;
  logic [2:0] n_tx, k;
  logic [7:0] byte_k;
  logic [2:0] tk;
  logic take;

  assign take = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.load = (state == S_IDLE) && in_valid;
    cmd.pkt_init = (state == S_PINIT);
    cmd.pkt_step = (state == S_PSTEP) && stat.pkt_run;
  end

  // byte k of the transmit sequence: optional ack, then the time message
  always_comb begin
    tk = stat.ack ? k - 3'd1 : k;
    if (stat.ack && k == 3'd0) byte_k = ACK_BYTE;
    else if (tk == 3'd0) byte_k = TIME_CMD_BYTE;
    else if (tk == 3'd6) byte_k = stat.house_byte;
    else byte_k = 8'h00;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0; k <= 3'd0; n_tx <= 3'd0;
      out_item <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid) state <= S_LOADED;
        S_LOADED: begin
          n_tx <= (stat.ack ? 3'd1 : 3'd0) + (stat.tmsg ? 3'd7 : 3'd0);
          k <= 3'd0;
          state <= stat.pkt_run ? S_PINIT : S_EMIT;
        end
        S_PINIT: state <= S_PSTEP;
        S_PSTEP: if (!stat.pkt_run) state <= S_EMIT;
        S_EMIT: if (take) begin
          out_valid <= 1'b1;
          out_item.video_enable <= video_enable;
          out_item.scanning <= scanning;
          if (n_tx == 3'd0 && !(stat.ack && stat.tmsg)) begin
            out_item.tx_valid <= 1'b0; out_item.tx_byte <= 8'h00;
            out_item.last <= 1'b1;
            state <= S_IDLE;
          end else begin
            out_item.tx_valid <= 1'b1; out_item.tx_byte <= byte_k;
            out_item.last <= (k == n_tx - 3'd1);
            k <= k + 3'd1;
            if (k == n_tx - 3'd1) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
